// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// Clocked assertion that also runs through reset.
`define ASSERT_CLK_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) \
    else $error(msg);

`endif

// File: hw/rtl/lifrk_pkg.sv
package lifrk_pkg;

  localparam int VOLT_WIDTH_DEF   = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // working width of the signed datapath
  localparam int WORK_W = 64;
  // fraction bits of voltage and coefficients, and the shift that widens a Q8.8 sample
  localparam int FRAC_W = 16;
  localparam int CUR_SH = 8;
  // step_dt is a Q0.32 fraction
  localparam int DT_W   = 32;

  // shared multiplier: one 32x32 chunk per cycle into a 96-bit accumulator
  localparam int MUL_W  = 32;
  localparam int ACC_W  = 3 * MUL_W;
  localparam int PMAG_W = WORK_W - 1;

  // divide by three, one byte per cycle: q = (x * RECIP3) >> RECIP3_SH
  localparam int DIGIT_W   = 8;
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;
  localparam int DIV3      = 3;

  // APB register map
  localparam int CFG_W  = 32;
  localparam int APB_AW = 4;
  localparam logic [APB_AW-3:0] REG_LEAK = 2'd0;
  localparam logic [APB_AW-3:0] REG_GAIN = 2'd1;
  localparam logic [APB_AW-3:0] REG_DT   = 2'd2;
  localparam logic [APB_AW-3:0] REG_THR  = 2'd3;

  localparam logic [CFG_W-1:0]        LEAK_RST = 32'd65536;
  localparam logic [CFG_W-1:0]        GAIN_RST = 32'd65536;
  localparam logic [CFG_W-1:0]        DT_RST   = 32'd42949673;
  localparam logic signed [CFG_W-1:0] THR_RST  = 32'sd65536;

  typedef enum logic [1:0] {
    SH_FRAC,
    SH_DT,
    SH_HALF_DT
  } shift_t;

  typedef struct packed {
    logic   first;
    logic   second;
    shift_t sh;
  } mul_ctl_t;

endpackage

// File: hw/rtl/lifrk_mul.sv
module lifrk_mul (
  input  logic                          clk,
  input  lifrk_pkg::mul_ctl_t           ctl,
  input  logic [lifrk_pkg::MUL_W-1:0]   a,
  input  logic [lifrk_pkg::MUL_W-1:0]   b,
  output logic [lifrk_pkg::PMAG_W-1:0]  pmag
);
  import lifrk_pkg::*;

  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;
  logic [ACC_W-1:0]   shifted;
  logic [2*MUL_W-1:0] prod;

  always_comb begin
    prod    = (2*MUL_W)'(a) * (2*MUL_W)'(b);
    acc_nxt = acc_r;
    if (ctl.first) begin
      acc_nxt = ACC_W'(prod);
    end else if (ctl.second) begin
      // upper chunk of the operand lands one chunk higher
      acc_nxt = acc_r + {prod, MUL_W'(0)};
    end
    case (ctl.sh)
      SH_FRAC:    shifted = acc_r >> FRAC_W;
      SH_DT:      shifted = acc_r >> DT_W;
      SH_HALF_DT: shifted = acc_r >> (DT_W + 1);
      default:    shifted = acc_r >> FRAC_W;
    endcase
    pmag = shifted[PMAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

// File: hw/rtl/lif_neuron_rk4_spiker.sv
// Leaky integrate-and-fire neuron, one RK4 step per consecutive sample pair.
// Input channel: in_valid/in_ready with in_current_sample (signed Q8.8) and
// in_trace_start. Result channel: out_valid/out_ready with out_spike, one word
// per sample from the third sample of a trace on.
// APB port: leak_rate, input_gain, step_dt, spike_threshold at 0x0..0xC;
// write only while the block is idle.
// A priming sample is taken while idle and in_ready stays high. Any later
// sample runs a full step before out_valid; the block is ready for the next
// word as soon as the result is registered. The step is set by the single
// 32x32 multiplier: twelve products in two chunks each, with a sequencer
// step after each, two operand loads per slope, then a byte-serial divide by
// six over ceil((VOLT_WIDTH+13)/8) bytes and the final step.
// Reset clears voltage, stored sample, trace progress and the output register,
// and loads the register defaults. If the receiver stalls, the finished word
// waits in the output register; the block may accept the next sample, but a
// new result holds in the final step until the register frees.
module lif_neuron_rk4_spiker #(
  parameter int VOLT_WIDTH   = lifrk_pkg::VOLT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = lifrk_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_current_sample,
  input  logic                                in_trace_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_spike,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lifrk_pkg::APB_AW-1:0]        paddr,
  input  logic [lifrk_pkg::CFG_W-1:0]         pwdata,
  output logic [lifrk_pkg::CFG_W-1:0]         prdata,
  output logic                                pready
);
  import lifrk_pkg::*;

  localparam int DW   = VOLT_WIDTH + 12;
  localparam int SUMW = DW + 3;
  localparam int CW   = SAMPLE_WIDTH + CUR_SH;
  localparam int OPW  = (CW > SUMW) ? CW : SUMW;
  localparam int QW   = SUMW - 2;
  localparam int NDIG = (QW + DIGIT_W - 1) / DIGIT_W;
  localparam int DVW  = NDIG * DIGIT_W;
  localparam int DCW  = (NDIG > 1) ? $clog2(NDIG) : 1;

  localparam logic signed [WORK_W-1:0] VMAX = (64'sd1 <<< (VOLT_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WORK_W-1:0] DMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ULD,
    ST_LEAK_LO,
    ST_LEAK_HI,
    ST_LEAK_FIN,
    ST_DRV_LO,
    ST_DRV_HI,
    ST_DRV_FIN,
    ST_KLD,
    ST_STG_LO,
    ST_STG_HI,
    ST_STG_FIN,
    ST_SUM_LO,
    ST_SUM_HI,
    ST_SUM_FIN,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] kidx_r, kidx_nxt;
  logic [1:0] prime_r, prime_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_spike_r, out_spike_nxt;

  logic signed [VOLT_WIDTH-1:0]   v_r, v_nxt;
  logic signed [VOLT_WIDTH-1:0]   u_r, u_nxt;
  logic signed [SAMPLE_WIDTH-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_WIDTH-1:0] samp_r, samp_nxt;
  logic signed [DW-1:0]           leak_r, leak_nxt;
  logic signed [DW-1:0]           k_r, k_nxt;
  logic signed [SUMW-1:0]         sum_r, sum_nxt;
  logic [OPW-1:0]                 opm_r, opm_nxt;
  logic                           neg_r, neg_nxt;
  logic [DVW-1:0]                 dv_r, dv_nxt;
  logic [1:0]                     rem_r, rem_nxt;
  logic [DCW-1:0]                 dig_r, dig_nxt;

  logic [CFG_W-1:0]        leak_rate_r, input_gain_r, step_dt_r;
  logic signed [CFG_W-1:0] spike_thr_r;
  logic                    cfg_wr;

  mul_ctl_t            mul_ctl;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PMAG_W-1:0]   pmag;
  logic [WORK_W-1:0]   op64;

  logic signed [WORK_W-1:0] p64, v64, u64, k64, sum64, leak64;
  logic signed [WORK_W-1:0] c0, c1, cm, cur64;
  logic signed [WORK_W-1:0] drive64, kk, kadd, q64, inc64, vnew64, thr64;
  logic                     fire;

  logic [DIGIT_W+1:0]   dx;
  logic [2*DIGIT_W+3:0] dxm;
  logic [DIGIT_W-1:0]   dq;
  logic [DIGIT_W+1:0]   drem;

  function automatic logic signed [WORK_W-1:0] clamp_to(
    input logic signed [WORK_W-1:0] x,
    input logic signed [WORK_W-1:0] hi
  );
    logic signed [WORK_W-1:0] lo;
    logic signed [WORK_W-1:0] res;
    lo  = ~hi;
    res = x;
    if (x > hi) begin
      res = hi;
    end else if (x < lo) begin
      res = lo;
    end
    return res;
  endfunction

  function automatic logic [OPW-1:0] mag_of(input logic signed [WORK_W-1:0] x);
    logic signed [WORK_W-1:0] m;
    m = (x < 0) ? -x : x;
    return OPW'(m);
  endfunction

  lifrk_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .pmag (pmag)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_spike = out_spike_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[APB_AW-1:2])
      REG_LEAK: prdata = leak_rate_r;
      REG_GAIN: prdata = input_gain_r;
      REG_DT:   prdata = step_dt_r;
      REG_THR:  prdata = spike_thr_r;
      default:  prdata = '0;
    endcase
  end

  // signed views of the stored values
  always_comb begin
    op64   = WORK_W'(opm_r);
    p64    = neg_r ? -$signed(WORK_W'(pmag)) : $signed(WORK_W'(pmag));
    v64    = WORK_W'(v_r);
    u64    = WORK_W'(u_r);
    k64    = WORK_W'(k_r);
    sum64  = WORK_W'(sum_r);
    leak64 = WORK_W'(leak_r);
    thr64  = WORK_W'(spike_thr_r);
    c0     = WORK_W'(prev_r) <<< CUR_SH;
    c1     = WORK_W'(samp_r) <<< CUR_SH;
    // half-step current is the exact mean of the two samples
    cm     = (WORK_W'(prev_r) + WORK_W'(samp_r)) <<< (CUR_SH - 1);
    case (kidx_r)
      2'd0:    cur64 = c0;
      2'd3:    cur64 = c1;
      default: cur64 = cm;
    endcase
    drive64 = clamp_to(p64, DMAX);
    kk      = clamp_to(drive64 - leak64, DMAX);
    kadd    = (kidx_r == 2'd1 || kidx_r == 2'd2) ? (kk <<< 1) : kk;
    q64     = WORK_W'(dv_r);
    inc64   = neg_r ? -$signed(q64) : $signed(q64);
    vnew64  = clamp_to(v64 + inc64, VMAX);
    fire    = (vnew64 > thr64);
    dx      = {rem_r, dv_r[DVW-1 -: DIGIT_W]};
    dxm     = (2*DIGIT_W+4)'(dx) * (2*DIGIT_W+4)'(RECIP3);
    dq      = dxm[RECIP3_SH +: DIGIT_W];
    drem    = dx - (DIGIT_W+2)'(dq) * (DIGIT_W+2)'(DIV3);
  end

  always_comb begin
    state_nxt     = state_r;
    kidx_nxt      = kidx_r;
    prime_nxt     = prime_r;
    out_valid_nxt = out_valid_r;
    out_spike_nxt = out_spike_r;
    v_nxt         = v_r;
    u_nxt         = u_r;
    prev_nxt      = prev_r;
    samp_nxt      = samp_r;
    leak_nxt      = leak_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    opm_nxt       = opm_r;
    neg_nxt       = neg_r;
    dv_nxt        = dv_r;
    rem_nxt       = rem_r;
    dig_nxt       = dig_r;
    mul_ctl       = '{first: 1'b0, second: 1'b0, sh: SH_FRAC};
    mul_a         = op64[MUL_W-1:0];
    mul_b         = leak_rate_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_trace_start || prime_r == 2'd0) begin
            v_nxt     = '0;
            prev_nxt  = in_current_sample;
            prime_nxt = 2'd1;
          end else if (prime_r == 2'd1) begin
            prev_nxt  = in_current_sample;
            prime_nxt = 2'd2;
          end else begin
            samp_nxt  = in_current_sample;
            u_nxt     = v_r;
            kidx_nxt  = 2'd0;
            sum_nxt   = '0;
            state_nxt = ST_ULD;
          end
        end
      end
      ST_ULD: begin
        opm_nxt   = mag_of(u64);
        neg_nxt   = u_r[VOLT_WIDTH-1];
        state_nxt = ST_LEAK_LO;
      end
      ST_LEAK_LO: begin
        mul_ctl.first = 1'b1;
        state_nxt     = ST_LEAK_HI;
      end
      ST_LEAK_HI: begin
        mul_ctl.second = 1'b1;
        mul_a          = op64[2*MUL_W-1:MUL_W];
        state_nxt      = ST_LEAK_FIN;
      end
      ST_LEAK_FIN: begin
        leak_nxt  = DW'(clamp_to(p64, DMAX));
        opm_nxt   = mag_of(cur64);
        neg_nxt   = (cur64 < 0);
        state_nxt = ST_DRV_LO;
      end
      ST_DRV_LO: begin
        mul_ctl.first = 1'b1;
        mul_b         = input_gain_r;
        state_nxt     = ST_DRV_HI;
      end
      ST_DRV_HI: begin
        mul_ctl.second = 1'b1;
        mul_a          = op64[2*MUL_W-1:MUL_W];
        mul_b          = input_gain_r;
        state_nxt      = ST_DRV_FIN;
      end
      ST_DRV_FIN: begin
        k_nxt     = DW'(kk);
        sum_nxt   = SUMW'(sum64 + kadd);
        state_nxt = ST_KLD;
      end
      ST_KLD: begin
        if (kidx_r == 2'd3) begin
          opm_nxt   = mag_of(sum64);
          neg_nxt   = sum_r[SUMW-1];
          state_nxt = ST_SUM_LO;
        end else begin
          opm_nxt   = mag_of(k64);
          neg_nxt   = k_r[DW-1];
          state_nxt = ST_STG_LO;
        end
      end
      ST_STG_LO: begin
        mul_ctl.first = 1'b1;
        mul_b         = step_dt_r;
        state_nxt     = ST_STG_HI;
      end
      ST_STG_HI: begin
        mul_ctl.second = 1'b1;
        mul_a          = op64[2*MUL_W-1:MUL_W];
        mul_b          = step_dt_r;
        state_nxt      = ST_STG_FIN;
      end
      ST_STG_FIN: begin
        // half steps for k2 and k3, full step for k4
        mul_ctl.sh = (kidx_r == 2'd2) ? SH_DT : SH_HALF_DT;
        u_nxt      = VOLT_WIDTH'(clamp_to(v64 + p64, VMAX));
        kidx_nxt   = kidx_r + 2'd1;
        state_nxt  = ST_ULD;
      end
      ST_SUM_LO: begin
        mul_ctl.first = 1'b1;
        mul_b         = step_dt_r;
        state_nxt     = ST_SUM_HI;
      end
      ST_SUM_HI: begin
        mul_ctl.second = 1'b1;
        mul_a          = op64[2*MUL_W-1:MUL_W];
        mul_b          = step_dt_r;
        state_nxt      = ST_SUM_FIN;
      end
      ST_SUM_FIN: begin
        // halve the magnitude here; the divide loop then works by three
        mul_ctl.sh = SH_DT;
        dv_nxt     = DVW'(pmag[QW:1]);
        rem_nxt    = '0;
        dig_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        dv_nxt  = {dv_r[DVW-DIGIT_W-1:0], dq};
        rem_nxt = drem[1:0];
        dig_nxt = dig_r + DCW'(1);
        if (dig_r == DCW'(NDIG - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_spike_nxt = fire;
          v_nxt         = fire ? '0 : VOLT_WIDTH'(vnew64);
          prev_nxt      = samp_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    u_r    <= u_nxt;
    samp_r <= samp_nxt;
    leak_r <= leak_nxt;
    k_r    <= k_nxt;
    sum_r  <= sum_nxt;
    opm_r  <= opm_nxt;
    neg_r  <= neg_nxt;
    dv_r   <= dv_nxt;
    rem_r  <= rem_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      kidx_r       <= '0;
      prime_r      <= '0;
      dig_r        <= '0;
      out_valid_r  <= 1'b0;
      out_spike_r  <= 1'b0;
      v_r          <= '0;
      prev_r       <= '0;
      leak_rate_r  <= LEAK_RST;
      input_gain_r <= GAIN_RST;
      step_dt_r    <= DT_RST;
      spike_thr_r  <= THR_RST;
    end else begin
      state_r     <= state_nxt;
      kidx_r      <= kidx_nxt;
      prime_r     <= prime_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
      out_spike_r <= out_spike_nxt;
      v_r         <= v_nxt;
      prev_r      <= prev_nxt;
      if (cfg_wr) begin
        case (paddr[APB_AW-1:2])
          REG_LEAK: leak_rate_r  <= pwdata;
          REG_GAIN: input_gain_r <= pwdata;
          REG_DT:   step_dt_r    <= pwdata;
          REG_THR:  spike_thr_r  <= pwdata;
          default:  leak_rate_r  <= leak_rate_r;
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/lifrk_chk.sv
`include "assert_macros.svh"

module lifrk_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_spike,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [lifrk_pkg::APB_AW-1:0]  paddr,
  input logic [lifrk_pkg::CFG_W-1:0]   pwdata,
  input logic [lifrk_pkg::CFG_W-1:0]   prdata
);

  // a result needs the whole step: never the cycle after a word is taken
  `ASSERT_CLK(a_no_instant_result, clk, rst_n, in_valid && in_ready |=> !$rose(out_valid), "result word rose right after an input word")

  // a new result is registered only from the busy final step
  `ASSERT_CLK(a_result_after_busy, clk, rst_n, $rose(out_valid) |-> $past(!in_ready), "result word appeared while idle")

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_spike), "stalled result word changed")

  `ASSERT_CLK_NR(a_reset_clears_out, clk, !rst_n |=> !out_valid, "result word valid after reset")

  // a written register reads back the written data while the address is held
  `ASSERT_CLK(a_cfg_readback, clk, rst_n, rst_n && psel && penable && pwrite |=> (paddr != $past(paddr)) || (prdata == $past(pwdata)), "register readback mismatch")

endmodule

bind lif_neuron_rk4_spiker lifrk_chk u_lifrk_chk (.*);
